>>> src/sorted_list_table_unit_assert.svh
`ifndef SORTED_LIST_TABLE_UNIT_ASSERT_SVH
`define SORTED_LIST_TABLE_UNIT_ASSERT_SVH

// clocked property, quiet during reset
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication that must hold from one edge to the next
`define SLT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> src/slt_pkg.sv
`default_nettype none

package slt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam int KEY_FIELD_W   = 32;
  localparam int POS_FIELD_W   = 4;
  localparam int ACT_FIELD_W   = 2;
  localparam int STAT_FIELD_W  = 2;
  localparam int COUNT_FIELD_W = 5;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [ACT_FIELD_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_FIELD_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } slt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } slt_stat_t;

endpackage

`default_nettype wire

>>> src/sorted_list_table_unit.sv
// sorted key table: keeps up to 16 unsigned 32-bit keys in ascending order
//
// input stream (s_*): one operation per transfer; s_tuser carries the action
// (insert, remove first equal key, read at position), s_tdata the key and the
// read position. output stream (m_*): exactly one result per operation, with
// the read key and entry count in m_tdata and the status in m_tuser.
//
// timing: an accepted operation is first captured in the operation registers
// (action, key, position); the key table and the result register are updated
// together afterwards, once the result register is free, and m_tvalid rises
// with that update. a new operation is taken only after the previous one has
// updated the table; all compares and the entry shift happen in that update.
//
// reset clears the entry count and empties the result register; key storage
// holds nothing readable until filled. if the receiver stalls, the result
// waits in the output register; one more operation is still accepted and then
// held until the register frees up.
`default_nettype none

module sorted_list_table_unit
  import slt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // key_value[31:0], position[35:32]
  input  wire logic [ACT_FIELD_W-1:0] s_tuser,   // action[1:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // read_key[31:0], entry_count[36:32]
  output logic [STAT_FIELD_W-1:0]     m_tuser    // status[1:0]
);

  slt_cmd_t                   cmd;
  slt_stat_t                  stat;
  logic [KEY_FIELD_W-1:0]     read_key;
  logic [COUNT_FIELD_W-1:0]   entry_count;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (s_tuser),
    .in_key_value (s_tdata[KEY_FIELD_W-1:0]),
    .in_position  (s_tdata[KEY_FIELD_W +: POS_FIELD_W]),
    .read_key     (read_key),
    .entry_count  (entry_count),
    .status       (m_tuser),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready)
  );

  assign m_tdata = {{(OUT_TDATA_W - KEY_FIELD_W - COUNT_FIELD_W){1'b0}}, entry_count, read_key};

endmodule

`default_nettype wire

>>> src/slt_ctrl.sv
`default_nettype none

module slt_ctrl
  import slt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire slt_stat_t stat,
  output slt_cmd_t       cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = s_tvalid && s_tready;
    cmd.exec = (state == EXEC) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            state    <= EXEC;
            s_tready <= 1'b0;
          end
        end
        EXEC: begin
          // wait here while the previous result is still stalled
          if (cmd.exec) begin
            state    <= IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/slt_datapath.sv
`default_nettype none

`include "sorted_list_table_unit_assert.svh"

module slt_datapath
  import slt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire slt_cmd_t                 cmd,
  output slt_stat_t                     stat,
  input  wire logic [ACT_FIELD_W-1:0]   in_action,
  input  wire logic [KEY_FIELD_W-1:0]   in_key_value,
  input  wire logic [POS_FIELD_W-1:0]   in_position,
  output logic [KEY_FIELD_W-1:0]        read_key,
  output logic [COUNT_FIELD_W-1:0]      entry_count,
  output logic [STAT_FIELD_W-1:0]       status,
  output logic                          out_valid,
  input  wire logic                     out_ready
);

  action_t act;
  key_t    key;
  idx_t    pos;

  key_t keys [CAPACITY];
  cnt_t count;

  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] lt_prev;
  logic [CAPACITY-1:0] eq;
  key_t                up   [CAPACITY];
  key_t                down [CAPACITY];
  key_t                keys_next [CAPACITY];
  cnt_t                count_next;
  key_t                rd_next;
  status_t             st_next;
  logic                found;
  logic                full;
  logic                in_range;

  assign stat.out_busy = out_valid && !out_ready;

  // parallel compare against every live entry; sorted order makes lt a prefix
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count) && (keys[i] < key);
      eq[i] = (CNT_W'(i) < count) && (keys[i] == key);
    end
    lt_prev[0] = 1'b1;
    up[0]      = key;
    for (int i = 1; i < CAPACITY; i++) begin
      lt_prev[i] = lt[i-1];
      up[i]      = keys[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      down[i] = keys[i+1];
    end
    down[CAPACITY-1] = keys[CAPACITY-1];
  end

  assign found    = |eq;
  assign full     = (count == cnt_t'(CAPACITY));
  assign in_range = ({1'b0, pos} < count);

  always_comb begin
    keys_next  = keys;
    count_next = count;
    rd_next    = '0;
    st_next    = ST_OK;
    unique case (act)
      ACT_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!lt[i]) begin
              keys_next[i] = lt_prev[i] ? key : up[i];
            end
          end
          count_next = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        // first equal key sits right after the run of smaller keys
        if (!found) begin
          st_next = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!lt[i]) begin
              keys_next[i] = down[i];
            end
          end
          count_next = count - 1'b1;
        end
      end
      ACT_READ: begin
        if (in_range) begin
          rd_next = keys[pos];
        end else begin
          st_next = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action_t'(in_action);
      key <= in_key_value[KEY_WIDTH-1:0];
      pos <= in_position[IDX_W-1:0];
    end
    if (cmd.exec) begin
      keys        <= keys_next;
      read_key    <= KEY_FIELD_W'(rd_next);
      entry_count <= COUNT_FIELD_W'(count_next);
      status      <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SLT_ASSERT(a_count_bound, count <= cnt_t'(CAPACITY), "entry count above capacity")
  `SLT_ASSERT_NEXT(a_insert_grows, cmd.exec && act == ACT_INSERT && !full,
    count == $past(count) + 1'b1, "insert did not add an entry")
  `SLT_ASSERT_NEXT(a_exec_result, cmd.exec, out_valid, "executed item left no result")
  `SLT_ASSERT(a_exec_free, !(cmd.exec && stat.out_busy), "result register overwritten")

endmodule

`default_nettype wire

>>> tb/tb_sorted_list_table_unit.sv
`timescale 1ns / 100ps

module tb_sorted_list_table_unit;
  import slt_pkg::*;

  typedef struct {
    action_t                act;
    key_t                   key;
    logic [POS_FIELD_W-1:0] pos;
    bit                     drain_first;  // hold off until every result is back
  } table_op_t;

  typedef struct {
    key_t    read_key;
    cnt_t    count;
    status_t status;
  } table_result_t;

  localparam int RANDOM_OPS = 1300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [ACT_FIELD_W-1:0] s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STAT_FIELD_W-1:0] m_tuser;

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];

  key_t shadow_keys[CAPACITY];
  int   shadow_count = 0;
  key_t key_pool[8];

  int   errors = 0;
  int   ops_accepted = 0;
  bit   in_taken = 1'b0;
  bit   rx_hold = 1'b0;
  int   tx_gap = 0;
  int   tx_burst = 0;
  int   rx_stall = 0;
  int   rx_burst = 0;
  table_op_t next_op;

  sorted_list_table_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // updates the shadow table and returns the result the block must give
  function automatic table_result_t apply_table_op(action_t act, key_t key,
                                                   logic [POS_FIELD_W-1:0] pos);
    table_result_t res;
    int slot;
    res.read_key = '0;
    res.status   = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_keys[slot] < key) slot++;
          for (int i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[slot] = key;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] != key) slot++;
        if (slot >= shadow_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = slot; i < shadow_count - 1; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
        end
      end
      ACT_READ: begin
        if (int'(pos) < shadow_count) res.read_key = shadow_keys[pos];
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    res.count = cnt_t'(shadow_count);
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, 7)];
    if (r < 80) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return key_t'($urandom);
  endfunction

  task automatic add_op(action_t act, key_t key, logic [POS_FIELD_W-1:0] pos,
                        bit drain_first);
    table_op_t op;
    op.act         = act;
    op.key         = key;
    op.pos         = pos;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // hold the current transfer
    end else if (tx_gap > 0) begin
      s_tvalid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (pending_ops.size() > 0 &&
                 !(pending_ops[0].drain_first && expected_results.size() > 0)) begin
      next_op  = pending_ops.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= {{(IN_TDATA_W-KEY_FIELD_W-POS_FIELD_W){1'b0}}, next_op.pos, next_op.key};
      s_tuser  <= next_op.act;
      if (tx_burst > 0) begin
        tx_burst <= tx_burst - 1;
        tx_gap   <= 0;
      end else if ($urandom_range(0, 49) == 0) begin
        tx_burst <= $urandom_range(20, 60);
        tx_gap   <= 0;
      end else begin
        tx_gap <= pick_gap();
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold) begin
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_burst > 0) begin
      m_tready <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      m_tready <= 1'b1;
      rx_burst <= $urandom_range(30, 100);
    end else if ($urandom_range(0, 99) < 20) begin
      m_tready <= 1'b0;
      rx_stall <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : monitor
    table_result_t exp_res;
    key_t    got_key;
    cnt_t    got_count;
    status_t got_status;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_table_op(action_t'(s_tuser),
                                                  s_tdata[KEY_FIELD_W-1:0],
                                                  s_tdata[KEY_FIELD_W +: POS_FIELD_W]));
        ops_accepted <= ops_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        got_key    = m_tdata[KEY_FIELD_W-1:0];
        got_count  = m_tdata[KEY_FIELD_W +: COUNT_FIELD_W];
        got_status = status_t'(m_tuser);
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_key %h, entry_count %0d, status %s",
                 got_key, got_count, got_status.name());
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got_key !== exp_res.read_key) begin
            $error("read_key: expected %h, got %h", exp_res.read_key, got_key);
            errors++;
          end
          if (got_count !== exp_res.count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.count, got_count);
            errors++;
          end
          if (got_status !== exp_res.status) begin
            $error("status: expected %s, got %s", exp_res.status.name(), got_status.name());
            errors++;
          end
        end
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (ops_accepted < 400) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("sorted_list_table_unit test failed");
    $finish;
  end

  initial begin
    int produced;
    int phase_len;
    int ins_w;
    int rem_w;
    int r;
    bit first_phase;
    action_t act;

    // directed: empty table, extremes, duplicates, full table, unused action
    add_op(ACT_READ, '0, 4'd0, 1'b0);
    add_op(ACT_READ, '1, 4'd15, 1'b0);
    add_op(ACT_REMOVE, key_t'(7), 4'd0, 1'b0);
    add_op(ACT_NONE, '1, 4'd15, 1'b0);
    add_op(ACT_INSERT, '0, 4'd0, 1'b0);
    add_op(ACT_INSERT, '1, 4'd0, 1'b0);
    add_op(ACT_INSERT, key_t'(5), 4'd0, 1'b0);
    add_op(ACT_INSERT, key_t'(5), 4'd0, 1'b0);
    add_op(ACT_READ, '0, 4'd1, 1'b0);
    add_op(ACT_READ, '0, 4'd4, 1'b0);
    add_op(ACT_REMOVE, key_t'(5), 4'd0, 1'b0);
    add_op(ACT_REMOVE, key_t'(6), 4'd0, 1'b0);
    for (int i = 0; i < CAPACITY - 3; i++) add_op(ACT_INSERT, key_t'($urandom), 4'd0, 1'b0);
    add_op(ACT_INSERT, key_t'(5), 4'd0, 1'b0);
    add_op(ACT_READ, '0, 4'd15, 1'b0);
    add_op(ACT_REMOVE, '1, 4'd0, 1'b0);
    add_op(ACT_NONE, '0, 4'd0, 1'b0);

    // random phases, each picked at random from filling, draining and a mix
    produced    = 0;
    first_phase = 1'b1;
    while (produced < RANDOM_OPS) begin
      for (int i = 0; i < 8; i++)
        key_pool[i] = ($urandom_range(0, 2) == 0) ? key_t'($urandom_range(0, 15))
                                                  : key_t'($urandom);
      case ($urandom_range(0, 2))
        0:       begin ins_w = 65; rem_w = 15; end
        1:       begin ins_w = 20; rem_w = 60; end
        default: begin ins_w = 40; rem_w = 30; end
      endcase
      phase_len = $urandom_range(40, 120);
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < ins_w) act = ACT_INSERT;
        else if (r < ins_w + rem_w) act = ACT_REMOVE;
        else if (r < 95) act = ACT_READ;
        else act = ACT_NONE;
        add_op(act, pick_key(), 4'($urandom_range(0, 15)),
               i == 0 && (first_phase || $urandom_range(0, 2) == 0));
      end
      first_phase = 1'b0;
      produced += phase_len;
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("sorted_list_table_unit test passed");
    end else begin
      $display("sorted_list_table_unit test failed");
    end
    $finish;
  end

endmodule
